// ----- design/uuidp_pkg.sv -----
// ----------------------------------------------------------------------------
// uuidp_pkg
// types, character codes and layout constants of the uuid text parser
// ----------------------------------------------------------------------------
package uuidp_pkg;

	// canonical text length and position counter
	localparam int unsigned TEXT_LEN = 36;
	localparam int unsigned POS_W    = $clog2(TEXT_LEN + 1);

	typedef logic [POS_W-1:0] pos_t;

	localparam pos_t TEXT_END   = pos_t'(TEXT_LEN);
	localparam pos_t DASH_POS_0 = pos_t'(8);
	localparam pos_t DASH_POS_1 = pos_t'(13);
	localparam pos_t DASH_POS_2 = pos_t'(18);
	localparam pos_t DASH_POS_3 = pos_t'(23);

	// identifier layout
	localparam int unsigned NIB_W  = 4;
	localparam int unsigned HALF_W = 64;
	localparam int unsigned ID_W   = 2 * HALF_W;
	localparam int unsigned WORD_W = 32;

	typedef logic [NIB_W-1:0] nib_t;

	// ascii codes
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;

	localparam nib_t HEX_ALPHA_BASE = nib_t'(10);

	// one character of text
	typedef struct packed {
		logic [7:0]        ch;
		logic              last;
		logic              mix_enable;
		logic [HALF_W-1:0] mix_hi;
		logic [HALF_W-1:0] mix_lo;
	} text_item_t;

	// one parse result
	typedef struct packed {
		logic              valid_res;
		logic [HALF_W-1:0] id_hi;
		logic [HALF_W-1:0] id_lo;
		logic [WORD_W-1:0] folded_id;
	} result_item_t;

	// classification of one character at its position
	typedef struct packed {
		logic past_end;
		logic dash_slot;
		logic is_dash;
		logic is_hex;
		nib_t nib;
	} char_class_t;

endpackage

// ----- design/uuidp_if.sv -----
// ----------------------------------------------------------------------------
// uuidp channel interfaces
// valid/ready channels for text characters and parse results
// ----------------------------------------------------------------------------
interface uuidp_text_if;
	logic                  valid;
	logic                  ready;
	uuidp_pkg::text_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface uuidp_result_if;
	logic                    valid;
	logic                    ready;
	uuidp_pkg::result_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- design/uuidp_char_class.sv -----
// ----------------------------------------------------------------------------
// uuidp_char_class
// classifies one character: hex value, hyphen, slot kind at its position
// ----------------------------------------------------------------------------
module uuidp_char_class (
	input  logic [7:0]             ch,
	input  uuidp_pkg::pos_t        pos,
	output uuidp_pkg::char_class_t cls
);
	import uuidp_pkg::*;

	logic       is_digit;
	logic       is_lower;
	logic       is_upper;
	logic [7:0] off_digit;
	logic [7:0] off_lower;
	logic [7:0] off_upper;

	assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_lower  = (ch >= CH_LOWER_A) && (ch <= CH_LOWER_F);
	assign is_upper  = (ch >= CH_UPPER_A) && (ch <= CH_UPPER_F);
	assign off_digit = ch - CH_ZERO;
	assign off_lower = ch - CH_LOWER_A;
	assign off_upper = ch - CH_UPPER_A;

	always_comb begin
		cls.past_end  = (pos >= TEXT_END);
		cls.dash_slot = (pos == DASH_POS_0) || (pos == DASH_POS_1) ||
		                (pos == DASH_POS_2) || (pos == DASH_POS_3);
		cls.is_dash   = (ch == CH_DASH);
		cls.is_hex    = is_digit || is_lower || is_upper;
		if (is_digit) begin
			cls.nib = off_digit[NIB_W-1:0];
		end else if (is_lower) begin
			cls.nib = off_lower[NIB_W-1:0] + HEX_ALPHA_BASE;
		end else if (is_upper) begin
			cls.nib = off_upper[NIB_W-1:0] + HEX_ALPHA_BASE;
		end else begin
			// bad digit packs as zero to keep later digits aligned
			cls.nib = '0;
		end
	end

endmodule

// ----- design/uuid_text_parser_unit.sv -----
// ----------------------------------------------------------------------------
// uuid_text_parser_unit
// streaming parser of 8-4-4-4-12 uuid text into a 128-bit identifier
// ----------------------------------------------------------------------------
//
// channel  direction  payload                                   transfer
// -------  ---------  ----------------------------------------  ------------------
// text     sink       ch, last, mix_enable, mix_hi, mix_lo      valid && ready
// result   source     valid_res, id_hi, id_lo, folded_id        valid && ready
//
// one character per cycle unless a last character waits behind a held result; a
// character is registered in the input register, and the result of a last
// character is then registered in the result register, which drives the result port
// arst_n clears the stage valids, the position, the format flag and the
// packed digits; payload registers are not reset
// a held result only stalls a last character waiting in the input register;
// ordinary characters keep flowing under a full result register
// ----------------------------------------------------------------------------
module uuid_text_parser_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	uuidp_text_if.sink            text,
	uuidp_result_if.source        result
);
	import uuidp_pkg::*;

	// input register
	logic        valid_s1;
	text_item_t  item_s1;

	// parse state
	pos_t             pos_q;
	logic             ok_q;
	logic [ID_W-1:0]  acc_q;

	// result register
	logic         res_valid_q;
	result_item_t res_q;

	char_class_t cls;
	logic        res_free;
	logic        adv_s1;
	logic        fire_res;

	pos_t             pos_n;
	logic             ok_n;
	logic [ID_W-1:0]  acc_n;
	logic [HALF_W-1:0] hi_n;
	logic [HALF_W-1:0] lo_n;

	uuidp_char_class u_class (
		.ch  (item_s1.ch),
		.pos (pos_q),
		.cls (cls)
	);

	// handshakes
	assign res_free   = !res_valid_q || result.ready;
	assign adv_s1     = valid_s1 && (!item_s1.last || res_free);
	assign fire_res   = adv_s1 && item_s1.last;
	assign text.ready = !valid_s1 || adv_s1;

	// next parse state for the character in the input register
	always_comb begin
		pos_n = pos_q;
		ok_n  = ok_q;
		acc_n = acc_q;
		if (cls.past_end) begin
			// too long: position saturates
			ok_n = 1'b0;
		end else if (cls.dash_slot) begin
			if (!cls.is_dash) begin
				ok_n = 1'b0;
			end
			pos_n = pos_q + pos_t'(1);
		end else begin
			if (!cls.is_hex) begin
				ok_n = 1'b0;
			end
			acc_n = {acc_q[ID_W-NIB_W-1:0], cls.nib};
			pos_n = pos_q + pos_t'(1);
		end
	end

	// optional mask on the final character
	always_comb begin
		hi_n = acc_n[ID_W-1:HALF_W];
		lo_n = acc_n[HALF_W-1:0];
		if (item_s1.mix_enable) begin
			hi_n = hi_n ^ item_s1.mix_hi;
			lo_n = lo_n ^ item_s1.mix_lo;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			item_s1 <= text.data;
		end
	end

	// parse state, back to reset values after each text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ok_q  <= 1'b1;
			acc_q <= '0;
		end else if (adv_s1) begin
			if (item_s1.last) begin
				pos_q <= '0;
				ok_q  <= 1'b1;
				acc_q <= '0;
			end else begin
				pos_q <= pos_n;
				ok_q  <= ok_n;
				acc_q <= acc_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_res) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_res) begin
			res_q.valid_res <= ok_n && (pos_n == TEXT_END);
			res_q.id_hi     <= hi_n;
			res_q.id_lo     <= lo_n;
			res_q.folded_id <= hi_n[HALF_W-1:WORD_W] ^ hi_n[WORD_W-1:0] ^
			                   lo_n[HALF_W-1:WORD_W] ^ lo_n[WORD_W-1:0];
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

`ifndef NO_ASSERTIONS
	// position never runs past the text length
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= TEXT_END)
		else $error("position beyond text length");

	// a final character clears the parse state
	a_text_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire_res |=> (pos_q == '0) && ok_q && (acc_q == '0))
		else $error("parse state not cleared after text end");

	// a new result never overwrites one still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		fire_res |-> (!res_valid_q || result.ready))
		else $error("result overwritten");

	// the input register only stalls on a final character behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |-> (item_s1.last && res_valid_q && !result.ready))
		else $error("input register stalled without cause");
`endif

endmodule
